// ----- rtl/isc_pkg.sv -----
// Shared constants, codes and link types of the interval set engine.
package isc_pkg;

	localparam int CAPACITY = 64;
	localparam int NCELL    = CAPACITY + 1;
	localparam int CNT_W    = $clog2(CAPACITY + 2);
	localparam int CP_W     = 21;
	localparam int FUNC_W   = 3;
	localparam int IDX_W    = 6;
	localparam int TOT_W    = 7;
	localparam int STAT_W   = 2;

	localparam logic [CP_W-1:0] UMAX_RESET = CP_W'(255);

	typedef enum logic [FUNC_W-1:0] {
		F_CLEAR  = 3'd0,
		F_ADD    = 3'd1,
		F_REMOVE = 3'd2,
		F_COMPL  = 3'd3,
		F_QUERY  = 3'd4,
		F_READ   = 3'd5
	} isc_func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_OVF   = 2'd1,
		ST_NOIDX = 2'd2
	} isc_stat_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_ADD,
		CM_REM,
		CM_CPL,
		CM_DEL
	} isc_mode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DEL,
		S_FIN
	} isc_state_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		isc_mode_t        mode;
		logic [CP_W-1:0]  lo;
		logic [CP_W-1:0]  hi;
		logic [CP_W-1:0]  umax;
		logic             any_mrg;
	} isc_bcast_t;

	// Handed from a cell to its right neighbor.
	typedef struct packed {
		logic [CP_W-1:0] lo;
		logic [CP_W-1:0] hi;
		logic            valid;
		logic            blw;
		logic            inu;
		logic            pre;
		logic            mrg;
		logic            sp_pre;
		logic            split;
	} isc_fwd_t;

	// Handed from a cell to its left neighbor.
	typedef struct packed {
		logic [CP_W-1:0] lo;
		logic [CP_W-1:0] hi;
		logic            del;
		logic            absb;
	} isc_bwd_t;

	// Per-cell status seen by the sequencer.
	typedef struct packed {
		logic mrg;
		logic split;
		logic memb;
		logic bnd;
		logic tpd;
		logic zero;
		logic del;
	} isc_flag_t;

endpackage

// ----- rtl/isc_req_if.sv -----
// Request channel carrying one operation.
interface isc_req_if;
	logic                       valid;
	logic                       ready;
	logic [isc_pkg::FUNC_W-1:0] func;
	logic [isc_pkg::CP_W-1:0]   range_lo;
	logic [isc_pkg::CP_W-1:0]   range_hi;
	logic [isc_pkg::CP_W-1:0]   code_point;
	logic [isc_pkg::IDX_W-1:0]  entry_index;

	modport src(output valid, func, range_lo, range_hi, code_point, entry_index, input ready);
	modport snk(input valid, func, range_lo, range_hi, code_point, entry_index, output ready);
endinterface

// ----- rtl/isc_rsp_if.sv -----
// Response channel carrying one result.
interface isc_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       is_member;
	logic [isc_pkg::CP_W-1:0]   entry_low;
	logic [isc_pkg::CP_W-1:0]   entry_high;
	logic [isc_pkg::TOT_W-1:0]  entry_total;
	logic [isc_pkg::STAT_W-1:0] status;

	modport src(output valid, is_member, entry_low, entry_high, entry_total, status,
		input ready);
	modport snk(input valid, is_member, entry_low, entry_high, entry_total, status,
		output ready);
endinterface

// ----- rtl/isc_cfg_if.sv -----
// Configuration write channel for the universe maximum.
interface isc_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [isc_pkg::CP_W-1:0] universe_max;

	modport src(output valid, universe_max, input ready);
	modport snk(input valid, universe_max, output ready);
endinterface

// ----- rtl/isc_cell.sv -----
// One cell of the interval chain: holds one entry and its merge/delete flags.
module isc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  isc_pkg::isc_bcast_t bc,
	input  logic                valid,
	input  isc_pkg::isc_fwd_t   lft,
	input  isc_pkg::isc_bwd_t   rgt,
	output isc_pkg::isc_fwd_t   fwd,
	output isc_pkg::isc_bwd_t   bwd,
	output isc_pkg::isc_flag_t  flg
);

	logic [isc_pkg::CP_W-1:0] lo_q, hi_q, lo_d, hi_d;
	logic                     del_q, abs_q, del_d, abs_d;
	logic                     blw, abv, mrg, ovl, split, inu, bnd, tpd, pre;
	logic [isc_pkg::CP_W:0]   hi_p1, bhi_p1;

	assign hi_p1  = {1'b0, hi_q} + (isc_pkg::CP_W+1)'(1);
	assign bhi_p1 = {1'b0, bc.hi} + (isc_pkg::CP_W+1)'(1);

	assign blw   = valid && (hi_p1 < {1'b0, bc.lo});
	assign abv   = valid && ({1'b0, lo_q} > bhi_p1);
	assign mrg   = valid && !blw && !abv;
	assign ovl   = valid && !(hi_q < bc.lo || lo_q > bc.hi);
	assign split = ovl && (lo_q < bc.lo) && (hi_q > bc.hi);
	assign inu   = valid && (lo_q <= bc.umax);
	assign bnd   = !inu && lft.inu;
	assign tpd   = bnd && lft.valid && (lft.hi >= bc.umax);
	assign pre   = del_q | lft.pre;

	assign fwd = '{lo: lo_q, hi: hi_q, valid: valid, blw: blw, inu: inu, pre: pre,
		mrg: mrg, sp_pre: split | lft.sp_pre, split: split};
	assign bwd = '{lo: lo_q, hi: hi_q, del: del_q, absb: abs_q};
	assign flg = '{mrg: mrg, split: split,
		memb: valid && (lo_q <= bc.lo) && (bc.lo <= hi_q),
		bnd: bnd, tpd: tpd, zero: inu && (lo_q == '0), del: del_q};

	always_comb begin
		lo_d  = lo_q;
		hi_d  = hi_q;
		del_d = del_q;
		abs_d = abs_q;
		unique case (bc.mode)
			isc_pkg::CM_HOLD: begin
			end
			isc_pkg::CM_ADD: begin
				del_d = 1'b0;
				abs_d = 1'b0;
				if (bc.any_mrg) begin
					if (mrg) begin
						hi_d = (hi_q > bc.hi) ? hi_q : bc.hi;
						if (!lft.mrg) begin
							lo_d  = (lo_q < bc.lo) ? lo_q : bc.lo;
							abs_d = 1'b1;
						end else begin
							del_d = 1'b1;
						end
					end
				end else if (lft.blw && !blw) begin
					lo_d = bc.lo;
					hi_d = bc.hi;
				end else if (!lft.blw && !blw) begin
					lo_d = lft.lo;
					hi_d = lft.hi;
				end
			end
			isc_pkg::CM_REM: begin
				del_d = 1'b0;
				abs_d = 1'b0;
				if (lft.split) begin
					lo_d = bc.hi + isc_pkg::CP_W'(1);
					hi_d = lft.hi;
				end else if (lft.sp_pre) begin
					lo_d = lft.lo;
					hi_d = lft.hi;
				end else if (split) begin
					hi_d = bc.lo - isc_pkg::CP_W'(1);
				end else if (ovl) begin
					if (lo_q < bc.lo)
						hi_d = bc.lo - isc_pkg::CP_W'(1);
					else if (hi_q > bc.hi)
						lo_d = bc.hi + isc_pkg::CP_W'(1);
					else
						del_d = 1'b1;
				end
			end
			isc_pkg::CM_CPL: begin
				del_d = 1'b0;
				abs_d = 1'b0;
				// The gap in front of each entry within the universe replaces it; the head link's
				// all-ones high end makes the first gap start at zero.
				if (inu) begin
					lo_d = lft.hi + isc_pkg::CP_W'(1);
					hi_d = lo_q - isc_pkg::CP_W'(1);
					if (lo_q == '0)
						del_d = 1'b1;
				end else if (bnd && !tpd) begin
					lo_d = lft.hi + isc_pkg::CP_W'(1);
					hi_d = bc.umax;
				end
			end
			isc_pkg::CM_DEL: begin
				if (pre) begin
					lo_d  = rgt.lo;
					hi_d  = rgt.hi;
					del_d = rgt.del;
					abs_d = rgt.absb;
				end else if (abs_q && rgt.del) begin
					hi_d = rgt.hi;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			del_q <= 1'b0;
			abs_q <= 1'b0;
		end else begin
			del_q <= del_d;
			abs_q <= abs_d;
		end
	end

endmodule

// ----- rtl/interval_set_engine.sv -----
// Top level of the interval set engine: sequencer, cell chain and result register.
// The set lives in a chain of CAPACITY+1 cells, one sorted interval per cell plus
// a spare at the end. Each operation is taken into a register, evaluated by every
// cell in parallel (merge, trim, split, insert or complement with the left
// neighbor's data), and then closes each deleted entry by shifting the cells
// above it one place left, one deleted entry per cycle. The entries deleted are
// those absorbed by an add, covered by a remove, or a leading entry at zero in
// a complement. A new operation is taken while the previous result still
// waits on the response channel. Configuration writes are always ready and
// take effect at once; write them only while the block is idle.
module interval_set_engine (
	input  logic      clk,
	input  logic      arst_n,
	isc_req_if.snk    req,
	isc_rsp_if.src    rsp,
	isc_cfg_if.snk    cfg
);

	isc_pkg::isc_state_t          state_q, state_d;
	logic [isc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic [isc_pkg::CP_W-1:0]     umax_q;
	isc_pkg::isc_func_t           func_q;
	logic [isc_pkg::CP_W-1:0]     lo_q, hi_q, cp_q;
	logic [isc_pkg::IDX_W-1:0]    idx_q;

	logic                         res_mem_q, res_mem_d;
	logic [isc_pkg::CP_W-1:0]     res_lo_q, res_hi_q, res_lo_d, res_hi_d;
	isc_pkg::isc_stat_t           res_st_q, res_st_d;

	logic                         out_vld_q;
	logic                         out_mem_q;
	logic [isc_pkg::CP_W-1:0]     out_lo_q, out_hi_q;
	logic [isc_pkg::TOT_W-1:0]    out_tot_q;
	logic [isc_pkg::STAT_W-1:0]   out_st_q;
	logic                         out_load;

	isc_pkg::isc_bcast_t          bc;
	isc_pkg::isc_mode_t           mode;
	isc_pkg::isc_fwd_t            head;
	isc_pkg::isc_bwd_t            tail;
	isc_pkg::isc_fwd_t            fwd [isc_pkg::NCELL];
	isc_pkg::isc_bwd_t            bwd [isc_pkg::NCELL];
	isc_pkg::isc_flag_t           flg [isc_pkg::NCELL];
	logic [isc_pkg::NCELL-1:0]    vld;

	logic                         any_mrg, any_split, any_del, topped, member;
	logic [isc_pkg::CNT_W-1:0]    p_cnt;
	logic [isc_pkg::CP_W-1:0]     sel_lo, sel_hi;

	assign head = '{lo: '0, hi: '1, valid: 1'b0, blw: 1'b1, inu: 1'b1, pre: 1'b0,
		mrg: 1'b0, sp_pre: 1'b0, split: 1'b0};
	assign tail = '{lo: '0, hi: '0, del: 1'b0, absb: 1'b0};

	assign bc = '{mode: mode, lo: (func_q == isc_pkg::F_QUERY) ? cp_q : lo_q,
		hi: hi_q, umax: umax_q, any_mrg: any_mrg};

	for (genvar k = 0; k < isc_pkg::NCELL; k++) begin : g_cell
		assign vld[k] = int'(cnt_q) > k;
		isc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bc     (bc),
			.valid  (vld[k]),
			.lft    ((k == 0) ? head : fwd[(k == 0) ? 0 : k-1]),
			.rgt    ((k == isc_pkg::NCELL-1) ? tail :
				bwd[(k == isc_pkg::NCELL-1) ? k : k+1]),
			.fwd    (fwd[k]),
			.bwd    (bwd[k]),
			.flg    (flg[k])
		);
	end

	always_comb begin
		any_mrg   = 1'b0;
		any_split = 1'b0;
		any_del   = 1'b0;
		topped    = 1'b0;
		member    = 1'b0;
		p_cnt     = '0;
		sel_lo    = '0;
		sel_hi    = '0;
		for (int k = 0; k < isc_pkg::NCELL; k++) begin
			any_mrg   = any_mrg   | flg[k].mrg;
			any_split = any_split | flg[k].split;
			any_del   = any_del   | flg[k].del;
			topped    = topped    | flg[k].tpd;
			member    = member    | flg[k].memb;
			p_cnt     = p_cnt | (flg[k].bnd ? isc_pkg::CNT_W'(k) : '0);
			if (int'(idx_q) == k) begin
				sel_lo = sel_lo | fwd[k].lo;
				sel_hi = sel_hi | fwd[k].hi;
			end
		end
	end

	assign out_load = (state_q == isc_pkg::S_FIN) && (!out_vld_q || rsp.ready);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		mode      = isc_pkg::CM_HOLD;
		res_mem_d = 1'b0;
		res_lo_d  = '0;
		res_hi_d  = '0;
		res_st_d  = isc_pkg::ST_OK;
		unique case (state_q)
			isc_pkg::S_IDLE: begin
				if (req.valid)
					state_d = isc_pkg::S_EXEC;
			end
			isc_pkg::S_EXEC: begin
				state_d = isc_pkg::S_DEL;
				unique case (func_q)
					isc_pkg::F_CLEAR: cnt_d = '0;
					isc_pkg::F_ADD: begin
						if (lo_q <= hi_q) begin
							if (!any_mrg && int'(cnt_q) == isc_pkg::CAPACITY) begin
								res_st_d = isc_pkg::ST_OVF;
							end else begin
								mode = isc_pkg::CM_ADD;
								if (!any_mrg)
									cnt_d = cnt_q + isc_pkg::CNT_W'(1);
							end
						end
					end
					isc_pkg::F_REMOVE: begin
						if (lo_q <= hi_q) begin
							if (any_split && int'(cnt_q) == isc_pkg::CAPACITY) begin
								res_st_d = isc_pkg::ST_OVF;
							end else begin
								mode = isc_pkg::CM_REM;
								if (any_split)
									cnt_d = cnt_q + isc_pkg::CNT_W'(1);
							end
						end
					end
					isc_pkg::F_COMPL: begin
						if (int'(p_cnt) == isc_pkg::CAPACITY && !topped && !flg[0].zero) begin
							res_st_d = isc_pkg::ST_OVF;
						end else begin
							mode  = isc_pkg::CM_CPL;
							cnt_d = p_cnt + isc_pkg::CNT_W'(!topped);
						end
					end
					isc_pkg::F_QUERY: res_mem_d = member;
					isc_pkg::F_READ: begin
						if (int'(idx_q) >= int'(cnt_q)) begin
							res_st_d = isc_pkg::ST_NOIDX;
						end else begin
							res_lo_d = sel_lo;
							res_hi_d = sel_hi;
						end
					end
					default: begin
					end
				endcase
			end
			isc_pkg::S_DEL: begin
				if (any_del) begin
					mode  = isc_pkg::CM_DEL;
					cnt_d = cnt_q - isc_pkg::CNT_W'(1);
				end else begin
					state_d = isc_pkg::S_FIN;
				end
			end
			isc_pkg::S_FIN: begin
				if (out_load)
					state_d = isc_pkg::S_IDLE;
			end
			default: state_d = isc_pkg::S_IDLE;
		endcase
	end

	assign req.ready = (state_q == isc_pkg::S_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= isc_pkg::S_IDLE;
			cnt_q     <= '0;
			umax_q    <= isc_pkg::UMAX_RESET;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg.valid)
				umax_q <= cfg.universe_max;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q <= isc_pkg::isc_func_t'(req.func);
			lo_q   <= req.range_lo;
			hi_q   <= req.range_hi;
			cp_q   <= req.code_point;
			idx_q  <= req.entry_index;
		end
		if (state_q == isc_pkg::S_EXEC) begin
			res_mem_q <= res_mem_d;
			res_lo_q  <= res_lo_d;
			res_hi_q  <= res_hi_d;
			res_st_q  <= res_st_d;
		end
		if (out_load) begin
			out_mem_q <= res_mem_q;
			out_lo_q  <= res_lo_q;
			out_hi_q  <= res_hi_q;
			out_tot_q <= isc_pkg::TOT_W'(cnt_q);
			out_st_q  <= res_st_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.is_member   = out_mem_q;
	assign rsp.entry_low   = out_lo_q;
	assign rsp.entry_high  = out_hi_q;
	assign rsp.entry_total = out_tot_q;
	assign rsp.status      = out_st_q;

`ifndef ASSERT_OFF
	// Only a complement may pass through the spare cell, and never while idle.
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isc_pkg::S_IDLE) |-> (int'(cnt_q) <= isc_pkg::CAPACITY))
		else $error("entry count above capacity while idle");

	// An overflowing operation leaves the entry count as it was.
	a_ovf_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isc_pkg::S_EXEC && res_st_d == isc_pkg::ST_OVF) |=>
		(cnt_q == $past(cnt_q)))
		else $error("overflow changed the entry count");

	// All pending deletions are closed before a result is published.
	a_del_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isc_pkg::S_FIN || state_q == isc_pkg::S_IDLE) |-> !any_del)
		else $error("deleted entry left open in the chain");
`endif

endmodule

// ----- verif/interval_set_engine_test.sv -----
// Self-checking testbench of the interval set engine with its own interval list.
module interval_set_engine_test;
	import isc_pkg::*;

	typedef struct packed {
		logic             member;
		logic [CP_W-1:0]  elo;
		logic [CP_W-1:0]  ehi;
		logic [TOT_W-1:0] total;
		logic [STAT_W-1:0] stat;
	} set_answer_t;

	class set_scoreboard;
		int unsigned lows[$];
		int unsigned highs[$];
		int unsigned umax;
		set_answer_t answers[$];
		int errors;

		function void reset_state();
			lows.delete();
			highs.delete();
			umax = UMAX_RESET;
			answers.delete();
			errors = 0;
		endfunction

		// Commit a new list unless it holds more than CAPACITY entries.
		function logic [STAT_W-1:0] commit(int unsigned nl[$], int unsigned nh[$]);
			if (nl.size() > CAPACITY) return ST_OVF;
			lows = nl;
			highs = nh;
			return ST_OK;
		endfunction

		function void note_op(logic [FUNC_W-1:0] f, int unsigned lo, int unsigned hi,
				int unsigned cp, int unsigned idx);
			set_answer_t a;
			int unsigned nl[$];
			int unsigned nh[$];
			int unsigned nxt;
			bit topped;
			a = '0;
			case (f)
				F_CLEAR: begin
					lows.delete();
					highs.delete();
				end
				F_ADD: if (lo <= hi) begin
					int k;
					k = 0;
					while (k < lows.size() && highs[k] + 1 < lo) begin
						nl.push_back(lows[k]);
						nh.push_back(highs[k]);
						k++;
					end
					while (k < lows.size() && lows[k] <= hi + 1) begin
						if (lows[k] < lo) lo = lows[k];
						if (highs[k] > hi) hi = highs[k];
						k++;
					end
					nl.push_back(lo);
					nh.push_back(hi);
					for (; k < lows.size(); k++) begin
						nl.push_back(lows[k]);
						nh.push_back(highs[k]);
					end
					a.stat = commit(nl, nh);
				end
				F_REMOVE: if (lo <= hi) begin
					foreach (lows[k]) begin
						if (highs[k] < lo || lows[k] > hi) begin
							nl.push_back(lows[k]);
							nh.push_back(highs[k]);
						end else begin
							if (lows[k] < lo) begin
								nl.push_back(lows[k]);
								nh.push_back(lo - 1);
							end
							if (highs[k] > hi) begin
								nl.push_back(hi + 1);
								nh.push_back(highs[k]);
							end
						end
					end
					a.stat = commit(nl, nh);
				end
				F_COMPL: begin
					nxt = 0;
					topped = 0;
					foreach (lows[k]) begin
						if (lows[k] > umax) break;
						if (lows[k] > nxt) begin
							nl.push_back(nxt);
							nh.push_back(lows[k] - 1);
						end
						if (highs[k] >= umax) begin
							topped = 1;
							break;
						end
						nxt = highs[k] + 1;
					end
					if (!topped) begin
						nl.push_back(nxt);
						nh.push_back(umax);
					end
					a.stat = commit(nl, nh);
				end
				F_QUERY: foreach (lows[k])
					if (cp >= lows[k] && cp <= highs[k]) a.member = 1'b1;
				F_READ: if (idx < lows.size()) begin
					a.elo = CP_W'(lows[idx]);
					a.ehi = CP_W'(highs[idx]);
				end else begin
					a.stat = ST_NOIDX;
				end
				default: ;
			endcase
			a.total = TOT_W'(lows.size());
			answers.push_back(a);
		endfunction

		function void check_result(set_answer_t got);
			set_answer_t want;
			if (answers.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = answers.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: member %b/%b low %h/%h high %h/%h",
						" total %0d/%0d status %0d/%0d"},
						want.member, got.member, want.elo, got.elo, want.ehi, got.ehi,
						want.total, got.total, want.stat, got.stat);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	isc_req_if req();
	isc_rsp_if rsp();
	isc_cfg_if cfg();
	set_scoreboard sb;
	int idle_cycles = 0;
	bit hold_rsp;
	bit send_done;

	interval_set_engine dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));

	always #4 clk = ~clk;

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Checks every accepted result and records every accepted request and configuration write at the rising edge.
	always @(posedge clk) begin
		bit moved;
		moved = 0;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				sb.check_result({rsp.is_member, rsp.entry_low, rsp.entry_high,
					rsp.entry_total, rsp.status});
				moved = 1;
			end
			if (req.valid && req.ready) begin
				sb.note_op(req.func, req.range_lo, req.range_hi, req.code_point,
					req.entry_index);
				moved = 1;
			end
			if (cfg.valid && cfg.ready) begin
				sb.umax = cfg.universe_max;
				moved = 1;
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (idle_cycles > 20000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Result side: random stalls, plus a long hold-off when asked.
	initial begin
		int g;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp.ready <= 0;
				repeat (300) @(negedge clk);
				hold_rsp = 0;
			end
			g = gap_len();
			if (g > 0 && $urandom_range(0, 2) == 0) begin
				rsp.ready <= 0;
				repeat (g - 1) @(negedge clk);
			end else begin
				rsp.ready <= 1;
			end
		end
	end

	task automatic send_op(logic [FUNC_W-1:0] f, int unsigned lo, int unsigned hi,
			int unsigned cp, int unsigned idx, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			req.valid <= 0;
			repeat (g) @(negedge clk);
		end
		req.valid <= 1;
		req.func <= f;
		req.range_lo <= CP_W'(lo);
		req.range_hi <= CP_W'(hi);
		req.code_point <= CP_W'(cp);
		req.entry_index <= IDX_W'(idx);
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 0;
		while (sb.answers.size() != 0) @(negedge clk);
		repeat (CAPACITY + 10) @(negedge clk);
	endtask

	task automatic write_umax(int unsigned v);
		drain();
		cfg.valid <= 1;
		cfg.universe_max <= CP_W'(v);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	// Points drawn from a narrow window most of the time so entries meet each other.
	function int unsigned pick_cp(int unsigned win);
		if ($urandom_range(0, 19) == 0) return $urandom_range(0, 2097151);
		return $urandom_range(0, win);
	endfunction

	task automatic random_op(int unsigned win, bit gaps);
		int r;
		int unsigned a, b;
		r = $urandom_range(0, 99);
		a = pick_cp(win);
		b = ($urandom_range(0, 9) == 0) ? pick_cp(win) : a + $urandom_range(0, win / 16);
		if (b > 2097151) b = 2097151;
		if (r < 2) send_op(F_CLEAR, a, b, 0, 0, gaps);
		else if (r < 40) send_op(F_ADD, a, b, $urandom, $urandom, gaps);
		else if (r < 58) send_op(F_REMOVE, a, b, $urandom, $urandom, gaps);
		else if (r < 63) send_op(F_COMPL, $urandom, $urandom, $urandom, $urandom, gaps);
		else if (r < 78) send_op(F_QUERY, $urandom, $urandom, pick_cp(win), 0, gaps);
		else if (r < 97) send_op(F_READ, $urandom, $urandom, 0, $urandom_range(0, 63), gaps);
		else send_op(FUNC_W'($urandom_range(6, 7)), a, b, a, 0, gaps);
	endtask

	initial begin
		int unsigned wins[4];
		sb = new();
		sb.reset_state();
		wins = '{255, 4095, 1023, 2097151};
		req.valid = 0;
		req.func = F_CLEAR;
		req.range_lo = 0;
		req.range_hi = 0;
		req.code_point = 0;
		req.entry_index = 0;
		cfg.valid = 0;
		cfg.universe_max = 0;
		hold_rsp = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part: extremes, every operation but clear and the special cases.
		send_op(F_READ, 0, 0, 0, 0, 0);
		send_op(F_COMPL, 0, 0, 0, 0, 0);
		send_op(F_QUERY, 0, 0, 255, 0, 0);
		send_op(F_QUERY, 0, 0, 256, 0, 0);
		send_op(F_ADD, 2097151, 2097151, 0, 0, 0);
		send_op(F_ADD, 300, 200, 0, 0, 0);
		send_op(F_REMOVE, 9, 5, 0, 0, 0);
		send_op(F_REMOVE, 10, 20, 0, 0, 0);
		send_op(F_ADD, 256, 400, 0, 0, 0);
		send_op(F_READ, 0, 0, 0, 63, 0);
		send_op(F_READ, 0, 0, 0, 1, 0);
		send_op(F_QUERY, 0, 0, 2097151, 0, 0);
		send_op(6, 1, 2, 3, 4, 0);
		send_op(7, 0, 0, 0, 0, 0);
		send_op(F_COMPL, 0, 0, 0, 0, 0);
		send_op(F_REMOVE, 0, 2097151, 0, 0, 0);
		// Fill to capacity with isolated points, then overflow with one more add.
		for (int k = 0; k < CAPACITY; k++) send_op(F_ADD, 4 * k, 4 * k, 0, 0, 1);
		send_op(F_ADD, 1000, 1000, 0, 0, 0);
		send_op(F_READ, 0, 0, 0, 63, 0);
		write_umax(2097151);
		send_op(F_COMPL, 0, 0, 0, 0, 0);
		send_op(F_ADD, 2, 2, 0, 0, 0);
		send_op(F_REMOVE, 1, 1, 0, 0, 0);
		send_op(F_ADD, 0, 2097151, 0, 0, 0);
		send_op(F_COMPL, 0, 0, 0, 0, 0);
		write_umax(0);
		send_op(F_COMPL, 0, 0, 0, 0, 0);
		send_op(F_COMPL, 0, 0, 0, 0, 0);

		// Random part in phases with different universe settings and windows.
		for (int ph = 0; ph < 4; ph++) begin
			write_umax(ph == 3 ? 2097151 : $urandom_range(0, wins[ph]));
			if (ph == 1) hold_rsp = 1;
			for (int n = 0; n < 200; n++) random_op(wins[ph], n % 60 < 40);
			if (ph == 2) drain();
		end
		drain();
		if (sb.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/isc_pkg.sv
rtl/isc_req_if.sv
rtl/isc_rsp_if.sv
rtl/isc_cfg_if.sv
rtl/isc_cell.sv
rtl/interval_set_engine.sv
verif/interval_set_engine_test.sv
